FILE: hdl/plfr_pkg.sv
// shared types and constants for the page lookup block with fifo replacement
// used by plfr_ctrl, plfr_dp and page_lookup_fifo_replace_core
`default_nettype none

package plfr_pkg;

    localparam int MAX_RESIDENT  = 8;
    localparam int PAGE_ELEMENTS = 256;
    localparam int INDEX_BITS    = 24;

    localparam int OFFSET_W = $clog2(PAGE_ELEMENTS);
    localparam int TAG_W    = 16;
    localparam int SLOT_W   = 3;
    localparam int COUNT_W  = 4;

    // controller to datapath
    typedef struct packed {
        logic load_in;   // capture the incoming beat
        logic ptr_inc;   // step the search pointer
        logic mark_hit;  // current slot matched
        logic install;   // place the page after a miss
        logic load_out;  // move the result into the output register
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic match;     // slot under the pointer is valid and holds the page
        logic at_end;    // pointer is at the last valid slot or table empty
        logic out_busy;  // output register holds a beat not yet taken
    } dp_status_t;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_SEARCH  = 4'b0010,
        ST_INSTALL = 4'b0100,
        ST_RESULT  = 4'b1000
    } ctrl_state_t;

endpackage

`default_nettype wire

FILE: hdl/plfr_ctrl.sv
// sequencer for the page lookup: accept, search slot by slot, install, deliver
// depends on plfr_pkg
`default_nettype none

module plfr_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  plfr_pkg::dp_status_t status,
    output plfr_pkg::ctrl_cmd_t  cmd
);

    plfr_pkg::ctrl_state_t state_reg;
    plfr_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= plfr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == plfr_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            plfr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = plfr_pkg::ST_SEARCH;
                end
            end
            plfr_pkg::ST_SEARCH:
            begin
                priority if (status.match)
                begin
                    cmd.mark_hit = 1'b1;
                    state_next   = plfr_pkg::ST_RESULT;
                end
                else if (status.at_end)
                begin
                    state_next = plfr_pkg::ST_INSTALL;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                end
            end
            plfr_pkg::ST_INSTALL:
            begin
                cmd.install = 1'b1;
                state_next  = plfr_pkg::ST_RESULT;
            end
            plfr_pkg::ST_RESULT:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = plfr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = plfr_pkg::ST_IDLE;
            end
        endcase
    end

    // a search never runs past the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == plfr_pkg::ST_SEARCH) && status.at_end && !status.match
            |=> state_reg == plfr_pkg::ST_INSTALL)
        else $error("search did not stop at the last valid slot");

    // every accepted beat leaves idle for the search
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == plfr_pkg::ST_SEARCH)
        else $error("accepted beat did not start a search");

    // install is always followed by result delivery
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.install |=> state_reg == plfr_pkg::ST_RESULT)
        else $error("install not followed by result");

endmodule

`default_nettype wire

FILE: hdl/plfr_dp.sv
// datapath: page split, resident tag table, fill count, fifo pointer, output register
// depends on plfr_pkg
`default_nettype none

module plfr_dp (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire  [plfr_pkg::INDEX_BITS-1:0]      element_index,
    input  wire                                  out_ready,
    input  plfr_pkg::ctrl_cmd_t                  cmd,
    output plfr_pkg::dp_status_t                 status,
    output logic                                 out_valid,
    output logic                                 hit,
    output logic [plfr_pkg::SLOT_W-1:0]          slot,
    output logic [plfr_pkg::TAG_W-1:0]           page_number,
    output logic [plfr_pkg::OFFSET_W-1:0]        offset_in_page,
    output logic                                 evicted_valid,
    output logic [plfr_pkg::TAG_W-1:0]           evicted_page
);

    localparam logic [plfr_pkg::COUNT_W-1:0] FULL_COUNT =
        plfr_pkg::COUNT_W'(plfr_pkg::MAX_RESIDENT);
    localparam logic [plfr_pkg::SLOT_W-1:0] LAST_SLOT =
        plfr_pkg::SLOT_W'(plfr_pkg::MAX_RESIDENT - 1);

    logic [plfr_pkg::TAG_W-1:0]    tag_mem [plfr_pkg::MAX_RESIDENT];

    logic [plfr_pkg::TAG_W-1:0]    page_reg;
    logic [plfr_pkg::OFFSET_W-1:0] offset_reg;
    logic [plfr_pkg::SLOT_W-1:0]   ptr_reg;
    logic [plfr_pkg::SLOT_W-1:0]   ptr_next;
    logic [plfr_pkg::COUNT_W-1:0]  count_reg;
    logic [plfr_pkg::COUNT_W-1:0]  count_next;
    logic [plfr_pkg::SLOT_W-1:0]   oldest_reg;
    logic [plfr_pkg::SLOT_W-1:0]   oldest_next;

    logic                          res_hit_reg;
    logic [plfr_pkg::SLOT_W-1:0]   res_slot_reg;
    logic                          res_ev_valid_reg;
    logic [plfr_pkg::TAG_W-1:0]    res_ev_page_reg;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          out_hit_reg;
    logic [plfr_pkg::SLOT_W-1:0]   out_slot_reg;
    logic [plfr_pkg::TAG_W-1:0]    out_page_reg;
    logic [plfr_pkg::OFFSET_W-1:0] out_offset_reg;
    logic                          out_ev_valid_reg;
    logic [plfr_pkg::TAG_W-1:0]    out_ev_page_reg;

    logic [plfr_pkg::SLOT_W-1:0]   rd_addr;
    logic [plfr_pkg::TAG_W-1:0]    rd_tag;
    logic [plfr_pkg::COUNT_W-1:0]  ptr_ext;
    logic                          full;
    logic [plfr_pkg::SLOT_W-1:0]   install_slot;

    // one read port: search pointer, or the oldest slot while installing
    assign rd_addr = cmd.install ? oldest_reg : ptr_reg;
    assign rd_tag  = tag_mem[rd_addr];
    assign ptr_ext = {1'b0, ptr_reg};
    assign full    = (count_reg == FULL_COUNT);

    // slots fill in order, so slot i is valid exactly when i < count
    assign status.match    = (ptr_ext < count_reg) && (rd_tag == page_reg);
    assign status.at_end   = ((ptr_ext + plfr_pkg::COUNT_W'(1)) >= count_reg);
    assign status.out_busy = out_valid_reg && !out_ready;

    assign install_slot = full ? oldest_reg : count_reg[plfr_pkg::SLOT_W-1:0];

    always_comb
    begin
        ptr_next    = ptr_reg;
        count_next  = count_reg;
        oldest_next = oldest_reg;
        if (cmd.load_in)
        begin
            ptr_next = '0;
        end
        else if (cmd.ptr_inc)
        begin
            ptr_next = ptr_reg + plfr_pkg::SLOT_W'(1);
        end
        if (cmd.install)
        begin
            if (full)
            begin
                oldest_next = (oldest_reg == LAST_SLOT) ? '0
                                                        : oldest_reg + plfr_pkg::SLOT_W'(1);
            end
            else
            begin
                count_next = count_reg + plfr_pkg::COUNT_W'(1);
            end
        end
        unique case ({cmd.load_out, out_ready})
            2'b10, 2'b11: out_valid_next = 1'b1;
            2'b01:        out_valid_next = 1'b0;
            2'b00:        out_valid_next = out_valid_reg;
            default:      out_valid_next = out_valid_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            count_reg     <= '0;
            oldest_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ptr_reg       <= ptr_next;
            count_reg     <= count_next;
            oldest_reg    <= oldest_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            offset_reg <= element_index[plfr_pkg::OFFSET_W-1:0];
            page_reg   <= element_index[plfr_pkg::OFFSET_W +: plfr_pkg::TAG_W];
        end
        if (cmd.mark_hit)
        begin
            res_hit_reg      <= 1'b1;
            res_slot_reg     <= ptr_reg;
            res_ev_valid_reg <= 1'b0;
            res_ev_page_reg  <= '0;
        end
        if (cmd.install)
        begin
            tag_mem[install_slot] <= page_reg;
            res_hit_reg           <= 1'b0;
            res_slot_reg          <= install_slot;
            res_ev_valid_reg      <= full;
            res_ev_page_reg       <= full ? rd_tag : '0;
        end
        if (cmd.load_out)
        begin
            out_hit_reg      <= res_hit_reg;
            out_slot_reg     <= res_slot_reg;
            out_page_reg     <= page_reg;
            out_offset_reg   <= offset_reg;
            out_ev_valid_reg <= res_ev_valid_reg;
            out_ev_page_reg  <= res_ev_page_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign hit            = out_hit_reg;
    assign slot           = out_slot_reg;
    assign page_number    = out_page_reg;
    assign offset_in_page = out_offset_reg;
    assign evicted_valid  = out_ev_valid_reg;
    assign evicted_page   = out_ev_page_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("resident count above table size");

    // fifo pointer only moves once the table has filled
    assert property (@(posedge clk) disable iff (!rst_n)
        !full |-> oldest_reg == '0)
        else $error("oldest slot moved before table full");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.install && !full |=> count_reg == $past(count_reg) + plfr_pkg::COUNT_W'(1))
        else $error("fill install did not bump count");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_hit_reg && out_ev_valid_reg))
        else $error("hit reported with an eviction");

endmodule

`default_nettype wire

FILE: hdl/page_lookup_fifo_replace_core.sv
// top level of the page lookup with fifo replacement: controller plus datapath
// depends on plfr_pkg, plfr_ctrl, plfr_dp
`default_nettype none

// Each input beat is a flat element index; the block splits it into page number
// (upper bits) and offset (low 8 bits), searches an 8-slot fully associative
// table of resident pages one slot per cycle, and on a miss installs the page,
// evicting the oldest page once all slots are in use. The result register is
// loaded after a search of k slots (1 to 8) on a hit, and after the search and
// an install step on a miss; the load waits while the output register holds a
// result not yet taken. A new index is taken only once the last result is loaded,
// and the compare runs slot by slot on the single tag read port. The result sits
// in an output register, so the next index is taken while the last result waits
// for out_ready. No clearing pass follows reset.
module page_lookup_fifo_replace_core (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  wire  [plfr_pkg::INDEX_BITS-1:0]      element_index,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output logic                                 hit,
    output logic [plfr_pkg::SLOT_W-1:0]          slot,
    output logic [plfr_pkg::TAG_W-1:0]           page_number,
    output logic [plfr_pkg::OFFSET_W-1:0]        offset_in_page,
    output logic                                 evicted_valid,
    output logic [plfr_pkg::TAG_W-1:0]           evicted_page
);

    plfr_pkg::ctrl_cmd_t  cmd;
    plfr_pkg::dp_status_t status;

    plfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    plfr_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .element_index  (element_index),
        .out_ready      (out_ready),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (out_valid),
        .hit            (hit),
        .slot           (slot),
        .page_number    (page_number),
        .offset_in_page (offset_in_page),
        .evicted_valid  (evicted_valid),
        .evicted_page   (evicted_page)
    );

endmodule

`default_nettype wire

FILE: tb/page_lookup_fifo_replace_core_tb.sv
// testbench for page_lookup_fifo_replace_core: random and directed index beats,
// predicted placements checked field by field. depends on plfr_pkg and the core
`timescale 1ns / 1ps

module page_lookup_fifo_replace_core_tb;

    typedef struct packed {
        logic                          hit;
        logic [plfr_pkg::SLOT_W-1:0]   slot;
        logic [plfr_pkg::TAG_W-1:0]    page;
        logic [plfr_pkg::OFFSET_W-1:0] offset;
        logic                          ev_valid;
        logic [plfr_pkg::TAG_W-1:0]    ev_page;
    } placement_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [plfr_pkg::INDEX_BITS-1:0] element_index = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic                            hit;
    logic [plfr_pkg::SLOT_W-1:0]     slot;
    logic [plfr_pkg::TAG_W-1:0]      page_number;
    logic [plfr_pkg::OFFSET_W-1:0]   offset_in_page;
    logic                            evicted_valid;
    logic [plfr_pkg::TAG_W-1:0]      evicted_page;

    // predictor state: resident table and fifo pointer
    logic [plfr_pkg::TAG_W-1:0]  tag_of [plfr_pkg::MAX_RESIDENT];
    logic                        slot_used [plfr_pkg::MAX_RESIDENT];
    logic [plfr_pkg::SLOT_W-1:0] oldest;
    int unsigned                 fill_count;

    logic [plfr_pkg::INDEX_BITS-1:0] index_queue [$];
    placement_t            placements_due [$];
    int unsigned           total_items;
    int unsigned           in_count = 0;
    int unsigned           errors = 0;
    logic                  in_taken = 1'b0;
    logic                  out_taken = 1'b0;
    int unsigned           send_gap = 0;
    int unsigned           send_burst = 0;
    int unsigned           recv_burst = 0;
    int unsigned           hold_left = 0;
    logic                  long_hold_done = 1'b0;

    page_lookup_fifo_replace_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .element_index  (element_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hit            (hit),
        .slot           (slot),
        .page_number    (page_number),
        .offset_in_page (offset_in_page),
        .evicted_valid  (evicted_valid),
        .evicted_page   (evicted_page)
    );

    always #2 clk = ~clk;

    function automatic placement_t place_page(input logic [plfr_pkg::INDEX_BITS-1:0] idx);
        placement_t                 r;
        logic [plfr_pkg::TAG_W-1:0] pg;
        r = '0;
        pg = plfr_pkg::TAG_W'(idx >> plfr_pkg::OFFSET_W);
        r.page = pg;
        r.offset = idx[plfr_pkg::OFFSET_W-1:0];
        for (int i = 0; i < plfr_pkg::MAX_RESIDENT; i++)
        begin
            if (!r.hit && slot_used[i] && tag_of[i] == pg)
            begin
                r.hit = 1'b1;
                r.slot = plfr_pkg::SLOT_W'(i);
            end
        end
        if (!r.hit)
        begin
            if (fill_count < plfr_pkg::MAX_RESIDENT)
            begin
                r.slot = plfr_pkg::SLOT_W'(fill_count);
                fill_count++;
            end
            else
            begin
                r.slot = oldest;
                r.ev_valid = 1'b1;
                r.ev_page = tag_of[oldest];
                oldest = plfr_pkg::SLOT_W'((oldest + 1) % plfr_pkg::MAX_RESIDENT);
            end
            tag_of[r.slot] = pg;
            slot_used[r.slot] = 1'b1;
        end
        return r;
    endfunction

    // mostly short gaps, a few long ones, and now and then a stretch of none
    function automatic int unsigned pick_gap(inout int unsigned burst);
        int unsigned r;
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r == 0)
        begin
            burst = $urandom_range(30, 80);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [plfr_pkg::INDEX_BITS-1:0] make_index(
        input logic [plfr_pkg::TAG_W-1:0]    pg,
        input logic [plfr_pkg::OFFSET_W-1:0] off);
        return plfr_pkg::INDEX_BITS'({pg, off});
    endfunction

    function automatic void add_index(input logic [plfr_pkg::INDEX_BITS-1:0] idx);
        index_queue.insert(index_queue.size(), idx);
    endfunction

    // sender
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (index_queue.size() > 0)
            begin
                element_index <= index_queue.pop_front();
                in_valid <= 1'b1;
                send_gap <= pick_gap(send_burst);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver, with one long hold so the core backs up into its input
    always @(negedge clk)
    begin
        int unsigned g;
        if (rst_n)
        begin
            if (!long_hold_done && in_count >= 400)
            begin
                out_ready <= 1'b0;
                hold_left <= 500;
                long_hold_done <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (out_taken)
            begin
                g = pick_gap(recv_burst);
                out_ready <= (g == 0);
                hold_left <= (g == 0) ? 0 : g - 1;
            end
            else
                out_ready <= ($urandom_range(0, 15) != 0);
        end
    end

    // monitor: predict on each index beat, check each result beat
    always @(posedge clk)
    begin
        placement_t want;
        in_taken <= rst_n && in_valid && in_ready;
        out_taken <= rst_n && out_valid && out_ready;
        if (rst_n && out_valid && out_ready)
        begin
            if (placements_due.size() == 0)
            begin
                $error("result beat with nothing outstanding");
                errors++;
            end
            else
            begin
                want = placements_due.pop_front();
                if (hit !== want.hit)
                begin
                    $error("hit: expected %0d, got %0d", want.hit, hit);
                    errors++;
                end
                if (slot !== want.slot)
                begin
                    $error("slot: expected %0d, got %0d", want.slot, slot);
                    errors++;
                end
                if (page_number !== want.page)
                begin
                    $error("page_number: expected %h, got %h", want.page, page_number);
                    errors++;
                end
                if (offset_in_page !== want.offset)
                begin
                    $error("offset_in_page: expected %h, got %h", want.offset, offset_in_page);
                    errors++;
                end
                if (evicted_valid !== want.ev_valid)
                begin
                    $error("evicted_valid: expected %0d, got %0d", want.ev_valid, evicted_valid);
                    errors++;
                end
                if (evicted_page !== want.ev_page)
                begin
                    $error("evicted_page: expected %h, got %h", want.ev_page, evicted_page);
                    errors++;
                end
            end
        end
        if (rst_n && in_valid && in_ready)
        begin
            placements_due.insert(placements_due.size(), place_page(element_index));
            in_count <= in_count + 1;
        end
    end

    initial
    begin
        logic [plfr_pkg::TAG_W-1:0] working_set [12];
        int unsigned                r;
        for (int i = 0; i < plfr_pkg::MAX_RESIDENT; i++)
        begin
            tag_of[i] = '0;
            slot_used[i] = 1'b0;
        end
        oldest = '0;
        fill_count = 0;

        // fill, hits at both offset extremes, then evict all the way round
        add_index(make_index(16'h0000, 8'h00));
        add_index(make_index(16'h0000, 8'hff));
        add_index(make_index(16'hffff, 8'hff));
        add_index(make_index(16'hffff, 8'h00));
        add_index(make_index(16'h5555, 8'h55));
        add_index(make_index(16'haaaa, 8'haa));
        add_index(make_index(16'h0001, 8'h01));
        add_index(make_index(16'h8000, 8'h80));
        add_index(make_index(16'h7fff, 8'h7f));
        add_index(make_index(16'h0100, 8'hfe));
        add_index(make_index(16'h1234, 8'h34));
        add_index(make_index(16'h0000, 8'h10));
        add_index(make_index(16'h1234, 8'hff));
        add_index(make_index(16'hffff, 8'h20));
        for (int p = 2; p < 8; p++)
            add_index(make_index(plfr_pkg::TAG_W'(p), plfr_pkg::OFFSET_W'(p * 31)));
        add_index(make_index(16'h0007, 8'h00));
        add_index(make_index(16'h0000, 8'hff));

        // random part: a drifting working set larger than the table, plus noise
        foreach (working_set[i])
            working_set[i] = plfr_pkg::TAG_W'($urandom);
        for (int n = 0; n < 1800; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                working_set[$urandom_range(0, 11)] = plfr_pkg::TAG_W'($urandom);
            if (r < 75)
                add_index(make_index(working_set[$urandom_range(0, 11)],
                                     plfr_pkg::OFFSET_W'($urandom)));
            else
                add_index(plfr_pkg::INDEX_BITS'($urandom));
        end
        total_items = index_queue.size();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (in_count == total_items);
        wait (placements_due.size() == 0);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("PASS page_lookup_fifo_replace_core");
        else
            $display("FAIL page_lookup_fifo_replace_core");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("FAIL page_lookup_fifo_replace_core");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/plfr_pkg.sv
hdl/plfr_ctrl.sv
hdl/plfr_dp.sv
hdl/page_lookup_fifo_replace_core.sv
tb/page_lookup_fifo_replace_core_tb.sv
